[rtl/ookrs_pkg.sv]
// ----------------------------------------------------------------------------
// ookrs_pkg
// Shared types and constants for the on-off-keyed remote switch encoder.
// ----------------------------------------------------------------------------
package ookrs_pkg;

   localparam int FRAME_W   = 40;
   localparam int INDEX_W   = 6;
   localparam int TICKS_W   = 13;
   localparam int UNITS_W   = 5;
   localparam int DELAY_W   = 8;
   localparam int REPEAT_W  = 8;
   localparam int KIND_W    = 2;
   localparam int CODE_W    = 24;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   // input item selector
   localparam logic [KIND_W-1:0] KIND_TICK      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START_F0  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START_TRI = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOP       = 2'd3;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_DELAY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_COUNT = 1'b1;

   localparam logic [DELAY_W-1:0]  UNIT_DELAY_RST   = 8'd100;
   localparam logic [REPEAT_W-1:0] REPEAT_COUNT_RST = 8'd4;

   // pulse lengths in units
   localparam logic [UNITS_W-1:0] LONG_UNITS  = 5'd12;
   localparam logic [UNITS_W-1:0] SHORT_UNITS = 5'd6;
   localparam logic [UNITS_W-1:0] TRI_ONE_HI  = 5'd13;
   localparam logic [UNITS_W-1:0] TRI_ONE_LO  = 5'd5;
   localparam logic [UNITS_W-1:0] TRI_ZERO_HI = 5'd7;
   localparam logic [UNITS_W-1:0] TRI_ZERO_LO = 5'd11;
   localparam logic [UNITS_W-1:0] SYNC_UNITS  = 5'd7;
   localparam logic [UNITS_W-1:0] GAP_UNITS   = 5'd24;

   // pulse counts; the index equal to the count is the trailing gap
   localparam logic [INDEX_W-1:0] PULSES_F0  = 6'd41;
   localparam logic [INDEX_W-1:0] PULSES_TRI = 6'd49;
   localparam logic [INDEX_W-1:0] HOUSE_BITS = 6'd24;
   localparam logic [INDEX_W-1:0] TRI_PAIRS_END = 6'd48;

   typedef struct packed {
      logic                format_mode;
      logic [FRAME_W-1:0]  frame_bits;
      logic [INDEX_W-1:0]  index;
      logic [DELAY_W-1:0]  unit_delay;
   } pulse_sel_type;

   typedef struct packed {
      logic [TICKS_W-1:0] ticks;
      logic               level;
   } pulse_load_type;

endpackage

[rtl/ookrs_pulse_table.sv]
// ----------------------------------------------------------------------------
// ookrs_pulse_table
// Length in ticks and line level of one pulse of the frame.
// ----------------------------------------------------------------------------
module ookrs_pulse_table (
   input  ookrs_pkg::pulse_sel_type  sel,
   output ookrs_pkg::pulse_load_type load
);
   import ookrs_pkg::*;

   logic [INDEX_W-1:0] count;
   logic [INDEX_W-1:0] bit_pos;
   logic [INDEX_W-2:0] pair;
   logic               data_bit;
   logic [UNITS_W-1:0] units;
   logic [DELAY_W-1:0] delay;
   logic               in_frame;

   always_comb begin
      count    = sel.format_mode ? PULSES_TRI : PULSES_F0;
      in_frame = (sel.index < count);
      pair     = sel.index[INDEX_W-1:1];
      bit_pos  = '0;
      units    = GAP_UNITS;
      if (!sel.format_mode) begin
         // house bits, inverted house LSB, then command bits
         if (sel.index < HOUSE_BITS) begin
            bit_pos = 6'd39 - sel.index;
         end else if (sel.index == HOUSE_BITS) begin
            bit_pos = 6'd16;
         end else if (in_frame) begin
            bit_pos = 6'd40 - sel.index;
         end
      end else begin
         if (sel.index < TRI_PAIRS_END) begin
            bit_pos = {1'b0, 5'd23 - pair};
         end
      end
      data_bit = sel.frame_bits[bit_pos];
      if (!in_frame) begin
         units = GAP_UNITS;
      end else if (!sel.format_mode) begin
         if (sel.index == HOUSE_BITS) begin
            units = data_bit ? SHORT_UNITS : LONG_UNITS;
         end else begin
            units = data_bit ? LONG_UNITS : SHORT_UNITS;
         end
      end else if (sel.index < TRI_PAIRS_END) begin
         if (data_bit) begin
            units = sel.index[0] ? TRI_ONE_LO : TRI_ONE_HI;
         end else begin
            units = sel.index[0] ? TRI_ZERO_LO : TRI_ZERO_HI;
         end
      end else begin
         units = SYNC_UNITS;
      end
      // zero delay counts as one tick per unit
      delay      = (sel.unit_delay == '0) ? DELAY_W'(1) : sel.unit_delay;
      load.ticks = TICKS_W'(units) * TICKS_W'(delay);
      load.level = in_frame & ~sel.index[0];
   end

endmodule

[rtl/ook_remote_switch_pulse_encoder_core.sv]
// ----------------------------------------------------------------------------
// ook_remote_switch_pulse_encoder_core
// On-off-keyed pulse encoder for remote power switches, driven one tick or
// start request at a time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | kind, house_code, command_bits
//  rsp_    | out       | rsp_valid/rsp_stall | tx_level, busy_res, start_ignored,
//          |           |                     | send_done
//  csr_    | in        | csr_valid/csr_ready | index, data (unit_delay, repeat_count)
//
//  One item per clock cycle sustained while rsp_ is not stalled; a result
//  passes through the input register, then the result register.
//  The pulse length is a 5x8 multiply between the two registers; no loop.
//  Reset is synchronous and returns the registers to 100 ticks per unit and
//  four repeats; no clearing pass is needed.
//  A stall on rsp_ holds the result register and backs up into req_stall
//  only when the input register is also full.
// ----------------------------------------------------------------------------
module ook_remote_switch_pulse_encoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ookrs_pkg::KIND_W-1:0]        req_kind,
   input  logic [ookrs_pkg::CODE_W-1:0]        req_house_code,
   input  logic [ookrs_pkg::CODE_W-1:0]        req_command_bits,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_tx_level,
   output logic                                rsp_busy_res,
   output logic                                rsp_start_ignored,
   output logic                                rsp_send_done,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ookrs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ookrs_pkg::CSR_DAT_W-1:0]     csr_data
);
   import ookrs_pkg::*;

   // configuration
   logic [DELAY_W-1:0]  unit_delay_ff, unit_delay_in;
   logic [REPEAT_W-1:0] repeat_count_ff, repeat_count_in;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]   s1_kind_ff;
   logic [CODE_W-1:0]   s1_house_ff;
   logic [CODE_W-1:0]   s1_cmd_ff;

   // encoder state
   logic [FRAME_W-1:0]  frame_bits_ff, frame_bits_in;
   logic                format_mode_ff, format_mode_in;
   logic                active_ff, active_in;
   logic [INDEX_W-1:0]  pulse_index_ff, pulse_index_in;
   logic [TICKS_W-1:0]  ticks_left_ff, ticks_left_in;
   logic [REPEAT_W-1:0] repeats_left_ff, repeats_left_in;
   logic                line_level_ff, line_level_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                tx_ff, tx_in;
   logic                busy_ff, busy_in;
   logic                ign_ff, ign_in;
   logic                done_ff, done_in;

   logic                in_take;
   logic                out_free;
   logic                s1_fire;
   logic                is_start;
   logic [FRAME_W-1:0]  start_frame;
   logic [TICKS_W-1:0]  ticks_dec;
   logic [INDEX_W-1:0]  count;
   logic                at_gap;
   logic [REPEAT_W-1:0] repeats_dec;
   pulse_sel_type       sel;
   pulse_load_type      load;

   // the registers are always writable
   assign csr_ready = 1'b1;

   // result register frees up when empty or being drained
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign s1_fire   = s1_valid_ff & out_free;
   assign req_stall = s1_valid_ff & ~out_free;
   assign in_take   = req_valid & ~req_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_level      = tx_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_start_ignored = ign_ff;
   assign rsp_send_done     = done_ff;

   always_comb begin
      unit_delay_in   = unit_delay_ff;
      repeat_count_in = repeat_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_UNIT_DELAY:   unit_delay_in   = csr_data;
            CSR_REPEAT_COUNT: repeat_count_in = csr_data;
            default:          ;
         endcase
      end
   end

   // pick what the pulse table looks at: the new frame on a start, the
   // held frame at the next pulse (or the first pulse of a repeat) on a tick
   always_comb begin
      is_start    = (s1_kind_ff == KIND_START_F0) || (s1_kind_ff == KIND_START_TRI);
      start_frame = (s1_kind_ff == KIND_START_TRI) ?
                    {16'b0, s1_cmd_ff} : {s1_house_ff, s1_cmd_ff[15:0]};
      count       = format_mode_ff ? PULSES_TRI : PULSES_F0;
      at_gap      = (pulse_index_ff >= count);
      ticks_dec   = (ticks_left_ff != '0) ? ticks_left_ff - TICKS_W'(1) : ticks_left_ff;
      repeats_dec = repeats_left_ff - REPEAT_W'(1);
      sel.unit_delay = unit_delay_ff;
      if (is_start) begin
         sel.format_mode = (s1_kind_ff == KIND_START_TRI);
         sel.frame_bits  = start_frame;
         sel.index       = '0;
      end else begin
         sel.format_mode = format_mode_ff;
         sel.frame_bits  = frame_bits_ff;
         sel.index       = at_gap ? '0 : pulse_index_ff + INDEX_W'(1);
      end
   end

   ookrs_pulse_table u_table (
      .sel  (sel),
      .load (load)
   );

   always_comb begin
      frame_bits_in   = frame_bits_ff;
      format_mode_in  = format_mode_ff;
      active_in       = active_ff;
      pulse_index_in  = pulse_index_ff;
      ticks_left_in   = ticks_left_ff;
      repeats_left_in = repeats_left_ff;
      line_level_in   = line_level_ff;
      tx_in           = tx_ff;
      busy_in         = busy_ff;
      ign_in          = ign_ff;
      done_in         = done_ff;
      if (s1_fire) begin
         tx_in   = line_level_ff;
         busy_in = active_ff;
         ign_in  = 1'b0;
         done_in = 1'b0;
         case (s1_kind_ff)
            KIND_TICK: begin
               if (active_ff) begin
                  ticks_left_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     if (at_gap) begin
                        // end of one repeat: drop out or restart the frame
                        repeats_left_in = repeats_dec;
                        pulse_index_in  = '0;
                        if (repeats_dec == '0) begin
                           active_in     = 1'b0;
                           line_level_in = 1'b0;
                           done_in       = 1'b1;
                        end else begin
                           ticks_left_in = load.ticks;
                           line_level_in = load.level;
                        end
                     end else begin
                        pulse_index_in = sel.index;
                        ticks_left_in  = load.ticks;
                        line_level_in  = load.level;
                     end
                  end
               end else begin
                  tx_in = 1'b0;
               end
            end
            KIND_START_F0, KIND_START_TRI: begin
               if (active_ff) begin
                  ign_in = 1'b1;
               end else if (repeat_count_ff != '0) begin
                  format_mode_in  = sel.format_mode;
                  frame_bits_in   = start_frame;
                  repeats_left_in = repeat_count_ff;
                  pulse_index_in  = '0;
                  active_in       = 1'b1;
                  ticks_left_in   = load.ticks;
                  line_level_in   = load.level;
                  tx_in           = load.level;
                  busy_in         = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (in_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_delay_ff   <= UNIT_DELAY_RST;
         repeat_count_ff <= REPEAT_COUNT_RST;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         frame_bits_ff   <= '0;
         format_mode_ff  <= 1'b0;
         active_ff       <= 1'b0;
         pulse_index_ff  <= '0;
         ticks_left_ff   <= '0;
         repeats_left_ff <= '0;
         line_level_ff   <= 1'b0;
      end else begin
         unit_delay_ff   <= unit_delay_in;
         repeat_count_ff <= repeat_count_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_bits_ff   <= frame_bits_in;
         format_mode_ff  <= format_mode_in;
         active_ff       <= active_in;
         pulse_index_ff  <= pulse_index_in;
         ticks_left_ff   <= ticks_left_in;
         repeats_left_ff <= repeats_left_in;
         line_level_ff   <= line_level_in;
      end
   end

   // payload registers: hold the item and the result, no reset
   always_ff @(posedge clock) begin
      if (in_take) begin
         s1_kind_ff  <= req_kind;
         s1_house_ff <= req_house_code;
         s1_cmd_ff   <= req_command_bits;
      end
      tx_ff   <= tx_in;
      busy_ff <= busy_in;
      ign_ff  <= ign_in;
      done_ff <= done_in;
   end

`ifndef SYNTHESIS
   // the final tick of a transmission still counts as busy
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> busy_ff)
      else $error("send_done without busy_res");

   // a start is only dropped while a transmission runs
   a_ign_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ign_ff |-> busy_ff)
      else $error("start_ignored while idle");

   // idle line stays low
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> !line_level_ff)
      else $error("line high while idle");

   // a running pulse never sits at zero ticks
   a_ticks_live: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ticks_left_ff != '0)
      else $error("active with no ticks left");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the OOK remote switch pulse encoder core. A queue of
// ticks and start requests feeds a bursty driver. A line predictor runs beside
// the core and works out the transmit level and flags for every transfer in.
// The monitor checks each result against the oldest prediction while the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
   import ookrs_pkg::*;

   // pulse lengths in timing units, as the encoder lays them out on the line
   localparam int unsigned U_LONG    = 12;
   localparam int unsigned U_SHORT   = 6;
   localparam int unsigned U_ONE_HI  = 13;
   localparam int unsigned U_ONE_LO  = 5;
   localparam int unsigned U_ZERO_HI = 7;
   localparam int unsigned U_ZERO_LO = 11;
   localparam int unsigned U_SYNC    = 7;
   localparam int unsigned U_GAP     = 24;
   localparam int unsigned FRAME0_PULSES = 41;
   localparam int unsigned TRI_PULSES    = 49;

   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned WATCHDOG_LIMIT  = 5000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] house;
      logic [CODE_W-1:0] cmd;
   } encoder_item_type;

   typedef struct packed {
      logic tx_level;
      logic busy;
      logic start_ignored;
      logic send_done;
   } line_result_type;

   // ---------------------------------------------------------------------------
   // clock, reset and the ports of the core; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind = KIND_NOP;
   logic [CODE_W-1:0]    req_house_code = '0;
   logic [CODE_W-1:0]    req_command_bits = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_tx_level;
   logic                 rsp_busy_res;
   logic                 rsp_start_ignored;
   logic                 rsp_send_done;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_UNIT_DELAY;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ook_remote_switch_pulse_encoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_house_code    (req_house_code),
      .req_command_bits  (req_command_bits),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_level      (rsp_tx_level),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_start_ignored (rsp_start_ignored),
      .rsp_send_done     (rsp_send_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // ---------------------------------------------------------------------------
   // bookkeeping shared between the processes
   // ---------------------------------------------------------------------------
   encoder_item_type outgoing_items[$];   // items waiting for the driver
   line_result_type  expected_lines[$];   // predictions waiting for their result

   int unsigned n_queued     = 0;
   int unsigned n_accepted   = 0;
   int unsigned n_results    = 0;
   int unsigned n_csr        = 0;
   int unsigned n_errors     = 0;
   int unsigned n_done_seen  = 0;
   int unsigned n_dropped    = 0;
   int unsigned idle_cycles  = 0;
   logic        req_took     = 1'b0;

   // ---------------------------------------------------------------------------
   // line predictor: own copy of the registers and of the pulse generator
   // ---------------------------------------------------------------------------
   logic [DELAY_W-1:0]  cfg_unit_delay   = 8'd100;
   logic [REPEAT_W-1:0] cfg_repeat_count = 8'd4;

   logic [FRAME_W-1:0]  enc_frame   = '0;
   logic                enc_tri     = 1'b0;   // second format: pulse pairs plus sync
   logic                enc_active  = 1'b0;
   logic [INDEX_W-1:0]  enc_index   = '0;
   logic [TICKS_W-1:0]  enc_ticks   = '0;
   logic [REPEAT_W-1:0] enc_repeats = '0;
   logic                enc_level   = 1'b0;

   function automatic int unsigned pulse_total();
      return enc_tri ? TRI_PULSES : FRAME0_PULSES;
   endfunction

   // length in units of pulse idx of the frame held; past the last pulse is the gap
   function automatic int unsigned pulse_units(input logic [INDEX_W-1:0] idx);
      int unsigned pos;
      logic        bit_val;
      pos = idx;
      if (pos >= pulse_total()) return U_GAP;
      if (!enc_tri) begin
         if (pos < 24) bit_val = enc_frame[39 - pos];
         else if (pos == 24) bit_val = ~enc_frame[16];   // inverted copy of the house LSB
         else bit_val = enc_frame[40 - pos];
         return bit_val ? U_LONG : U_SHORT;
      end
      if (pos < 48) begin
         bit_val = enc_frame[23 - pos / 2];
         if (bit_val) return idx[0] ? U_ONE_LO : U_ONE_HI;
         return idx[0] ? U_ZERO_LO : U_ZERO_HI;
      end
      return U_SYNC;
   endfunction

   // load the counter and level for the pulse at enc_index; a zero delay counts as one
   task automatic load_pulse();
      logic [31:0] delay;
      logic [31:0] span;
      delay = (cfg_unit_delay == 0) ? 32'd1 : {24'd0, cfg_unit_delay};
      span = pulse_units(enc_index) * delay;
      enc_ticks = span[TICKS_W-1:0];
      enc_level = (enc_index < pulse_total()) ? ~enc_index[0] : 1'b0;
   endtask

   task automatic predict_line(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] house,
                               input logic [CODE_W-1:0] cmd, output line_result_type res);
      res = '0;
      case (kind)
         KIND_TICK: begin
            if (enc_active) begin
               res.tx_level = enc_level;
               res.busy = 1'b1;
               if (enc_ticks != 0) enc_ticks = enc_ticks - 1'b1;
               if (enc_ticks == 0) begin
                  if (enc_index >= pulse_total()) begin
                     // end of the gap: close this repetition
                     enc_repeats = enc_repeats - 1'b1;
                     enc_index = '0;
                     if (enc_repeats == 0) begin
                        enc_active = 1'b0;
                        enc_level = 1'b0;
                        res.send_done = 1'b1;
                     end else begin
                        load_pulse();
                     end
                  end else begin
                     enc_index = enc_index + 1'b1;
                     load_pulse();
                  end
               end
            end
         end
         KIND_START_F0, KIND_START_TRI: begin
            if (enc_active) begin
               res.start_ignored = 1'b1;
            end else if (cfg_repeat_count != 0) begin
               enc_tri = (kind == KIND_START_TRI);
               enc_frame = enc_tri ? {16'h0000, cmd} : {house, cmd[15:0]};
               enc_repeats = cfg_repeat_count;
               enc_index = '0;
               enc_active = 1'b1;
               load_pulse();
            end
            res.tx_level = enc_level;
            res.busy = enc_active;
         end
         default: begin
            res.tx_level = enc_level;
            res.busy = enc_active;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         n_errors++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // monitor: sample every channel at the rising edge, predict on each transfer
   // in, check each transfer out against the oldest prediction, run the watchdog
   // ---------------------------------------------------------------------------
   line_result_type predicted;
   line_result_type observed;
   line_result_type oldest;

   always @(posedge clock) begin
      req_took = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            predict_line(req_kind, req_house_code, req_command_bits, predicted);
            expected_lines.push_back(predicted);
            n_accepted++;
         end
         if (csr_valid && csr_ready) begin
            n_csr++;
            if (csr_index == CSR_UNIT_DELAY) cfg_unit_delay = csr_data;
            else cfg_repeat_count = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            observed = '{rsp_tx_level, rsp_busy_res, rsp_start_ignored, rsp_send_done};
            n_results++;
            if (observed.send_done) n_done_seen++;
            if (observed.start_ignored) n_dropped++;
            if (expected_lines.size() == 0) begin
               $error("result transfer with no prediction outstanding");
               n_errors++;
            end else begin
               oldest = expected_lines.pop_front();
               check_field("tx_level", oldest.tx_level, observed.tx_level);
               check_field("busy_res", oldest.busy, observed.busy);
               check_field("start_ignored", oldest.start_ignored, observed.start_ignored);
               check_field("send_done", oldest.send_done, observed.send_done);
            end
         end
         // restart the count on any transfer; give up once the line has gone quiet
         if (req_took || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end else begin
            idle_cycles++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // driver: bursts of transfers separated by random gaps; hold a stalled item
   // ---------------------------------------------------------------------------
   encoder_item_type next_item;
   int unsigned      burst_left = 0;
   int unsigned      gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // stalled: keep valid and payload as they are
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (outgoing_items.size() != 0) begin
         next_item = outgoing_items.pop_front();
         req_kind <= next_item.kind;
         req_house_code <= next_item.house;
         req_command_bits <= next_item.cmd;
         req_valid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         end else begin
            burst_left--;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: stall on a pattern of its own, changing density every so often;
   // once, hold off for a long stretch so the core fills and stalls its input
   // ---------------------------------------------------------------------------
   int unsigned stall_span = 0;
   int unsigned stall_pct  = 0;
   int unsigned hold_left  = 0;
   logic        hold_used  = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_used && n_results >= 200 && outgoing_items.size() >= 16) begin
         hold_used = 1'b1;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_span == 0) begin
            stall_span = $urandom_range(16, 160);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 15;
               2: stall_pct = 40;
               default: stall_pct = 80;
            endcase
         end else begin
            stall_span--;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   function automatic logic [CODE_W-1:0] rand24();
      logic [31:0] r;
      r = $urandom;
      return r[CODE_W-1:0];
   endfunction

   function automatic logic [KIND_W-1:0] rand_start();
      return ($urandom_range(0, 1) == 0) ? KIND_START_F0 : KIND_START_TRI;
   endfunction

   task automatic offer(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] house,
                        input logic [CODE_W-1:0] cmd);
      encoder_item_type item;
      item.kind = kind;
      item.house = house;
      item.cmd = cmd;
      outgoing_items.push_back(item);
      n_queued++;
   endtask

   // wait until every queued item has gone in and every result has come back
   task automatic settle();
      while (n_accepted != n_queued || expected_lines.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      int unsigned seen;
      seen = n_csr;
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      while (n_csr == seen) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // feed ticks, with the odd no-op and start request mixed in, until the
   // predicted line has gone idle
   task automatic run_until_quiet();
      int unsigned n;
      int unsigned pick;
      do begin
         for (n = 0; n < 32; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 1) offer(rand_start(), rand24(), rand24());
            else if (pick < 4) offer(KIND_NOP, rand24(), rand24());
            else offer(KIND_TICK, rand24(), rand24());
         end
         settle();
      end while (enc_active);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: an idle tick and a no-op leave the line low
      offer(KIND_TICK, 24'hFFFFFF, 24'hFFFFFF);
      offer(KIND_NOP, 24'hFFFFFF, 24'hFFFFFF);
      settle();

      // first format, two repeats: a long first pulse past eight bits of ticks,
      // a short inverted house LSB and command bits above 16 dropped; two
      // starts are dropped while busy and a no-op goes in while busy
      write_reg(CSR_UNIT_DELAY, 8'd22);
      write_reg(CSR_REPEAT_COUNT, 8'd2);
      offer(KIND_START_F0, 24'h800001, 24'hFF0000);
      offer(KIND_START_TRI, 24'h000000, 24'hFFFFFF);
      offer(KIND_START_F0, 24'h000000, 24'h000000);
      offer(KIND_NOP, 24'h000000, 24'h000000);
      repeat (3) offer(KIND_TICK, 24'h000000, 24'h000000);
      settle();
      // zero unit delay while the first pulse is going out: one tick per unit
      // from the next pulse on, and both repeats then run to the end
      write_reg(CSR_UNIT_DELAY, 8'd0);
      run_until_quiet();

      // zero repeat count: the start is taken but nothing goes out
      write_reg(CSR_REPEAT_COUNT, 8'd0);
      offer(KIND_START_TRI, 24'hFFFFFF, 24'hFFFFFF);
      offer(KIND_TICK, 24'hFFFFFF, 24'hFFFFFF);
      settle();

      // tri-bit format, one repeat, random command bits
      write_reg(CSR_UNIT_DELAY, 8'd1);
      write_reg(CSR_REPEAT_COUNT, 8'd1);
      offer(KIND_START_TRI, rand24(), rand24());
      run_until_quiet();

      // results pass through the input and result registers; leave room for strays
      repeat (8) @(negedge clock);

      $display("covered %0d transfers in, %0d results, %0d register writes, both formats",
               n_accepted, n_results, n_csr);
      $display("%0d transmissions completed, %0d starts dropped while busy, %0d mismatches",
               n_done_seen, n_dropped, n_errors);
      if (n_errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/ookrs_pkg.sv
rtl/ookrs_pulse_table.sv
rtl/ook_remote_switch_pulse_encoder_core.sv
test/testbench.sv
